// File: hdl/tfe_pkg.sv
// shared constants, types and codes for the timed rgba fade engine
`timescale 1ns / 1ps

package tfe_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int TIME_BITS    = 16;
	localparam int NUM_LANES    = 4;
	localparam int ALPHA_LANE   = 3;
	localparam int CNT_BITS     = $clog2(CHANNEL_BITS);

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [TIME_BITS-1:0]    time_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef chan_t [NUM_LANES-1:0]   color_t;

	localparam chan_t CMAX     = {CHANNEL_BITS{1'b1}};
	localparam time_t TMAX     = {TIME_BITS{1'b1}};
	localparam cnt_t  CNT_LAST = CNT_BITS'(CHANNEL_BITS - 1);

	// function codes of a request
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef struct packed {
		logic  func;
		chan_t target_red;
		chan_t target_green;
		chan_t target_blue;
		chan_t target_alpha;
		time_t duration_ms;
		time_t elapsed_ms;
	} req_t;

	typedef struct packed {
		chan_t cur_red;
		chan_t cur_green;
		chan_t cur_blue;
		chan_t cur_alpha;
		chan_t modulation;
		logic  overlay_on;
		logic  busy_res;
	} rsp_t;

	// lane sequencing from the control fsm
	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	// architectural fade state that a tick may change
	typedef struct packed {
		color_t now;
		logic   in_progress;
		logic   overlay;
		chan_t  mod;
	} fade_upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_DONE
	} fade_state_t;

endpackage

// File: hdl/tfe_lane.sv
// one interpolation lane: product register and restoring divider
`timescale 1ns / 1ps

module tfe_lane (
	input  logic                clk,
	input  tfe_pkg::lane_ctl_t  ctl,
	input  tfe_pkg::chan_t      from,
	input  tfe_pkg::chan_t      to,
	input  tfe_pkg::time_t      t,
	input  tfe_pkg::time_t      e,
	output tfe_pkg::chan_t      value
);

	logic                                         neg;
	tfe_pkg::chan_t                               diff;
	logic [tfe_pkg::CHANNEL_BITS+tfe_pkg::TIME_BITS-1:0] prod;
	logic [tfe_pkg::TIME_BITS-1:0]                rem_q;
	tfe_pkg::chan_t                               quo_q;
	logic [tfe_pkg::TIME_BITS:0]                  shifted;
	logic [tfe_pkg::TIME_BITS+1:0]                trial;

	assign neg     = (to < from);
	assign diff    = neg ? (from - to) : (to - from);
	assign prod    = diff * t;
	assign shifted = {rem_q, quo_q[tfe_pkg::CHANNEL_BITS-1]};
	assign trial   = {1'b0, shifted} - {2'b00, e};

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= prod[tfe_pkg::CHANNEL_BITS+tfe_pkg::TIME_BITS-1:tfe_pkg::CHANNEL_BITS];
			quo_q <= prod[tfe_pkg::CHANNEL_BITS-1:0];
		end else if (ctl.step) begin
			if (!trial[tfe_pkg::TIME_BITS+1]) begin
				rem_q <= trial[tfe_pkg::TIME_BITS-1:0];
				quo_q <= {quo_q[tfe_pkg::CHANNEL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[tfe_pkg::TIME_BITS-1:0];
				quo_q <= {quo_q[tfe_pkg::CHANNEL_BITS-2:0], 1'b0};
			end
		end
	end

	// truncation toward the start value
	assign value = neg ? (from - quo_q) : (from + quo_q);

endmodule

// File: hdl/tfe_merge.sv
// merging stage: applies the tick rules to the lane results
`timescale 1ns / 1ps

module tfe_merge (
	input  tfe_pkg::color_t     start_color,
	input  tfe_pkg::color_t     goal_color,
	input  tfe_pkg::color_t     lane_val,
	input  tfe_pkg::fade_upd_t  cur,
	input  logic                reached,
	output tfe_pkg::fade_upd_t  upd
);

	logic goal_rgb_zero;
	logic goal_clear;
	logic start_clear;

	assign goal_rgb_zero = (goal_color[0] == '0) && (goal_color[1] == '0)
		&& (goal_color[2] == '0);
	assign goal_clear    = (goal_color[tfe_pkg::ALPHA_LANE] == '0);
	assign start_clear   = (start_color[tfe_pkg::ALPHA_LANE] == '0);

	always_comb begin
		upd = cur;
		if (cur.in_progress) begin
			if (reached) begin
				// snap to the target and settle overlay and modulation
				upd.now         = goal_color;
				upd.in_progress = 1'b0;
				if (cur.overlay) begin
					if (goal_clear || goal_rgb_zero) begin
						upd.overlay = 1'b0;
						upd.mod     = tfe_pkg::CMAX - goal_color[tfe_pkg::ALPHA_LANE];
					end
				end else begin
					upd.mod = tfe_pkg::CMAX - goal_color[tfe_pkg::ALPHA_LANE];
				end
			end else begin
				upd.now[tfe_pkg::ALPHA_LANE] = lane_val[tfe_pkg::ALPHA_LANE];
				for (int k = 0; k < tfe_pkg::ALPHA_LANE; k++) begin
					if (goal_clear) begin
						upd.now[k] = start_color[k];
					end else if (start_clear) begin
						upd.now[k] = goal_color[k];
					end else begin
						upd.now[k] = lane_val[k];
					end
				end
				if (!cur.overlay) begin
					upd.mod = tfe_pkg::CMAX - lane_val[tfe_pkg::ALPHA_LANE];
				end
			end
		end
	end

endmodule

// File: hdl/timed_rgba_fade_engine.sv
// top level of the timed rgba fade engine: control, state, lanes and result register
`timescale 1ns / 1ps

// channel | handshake            | payload
// req     | req_valid/req_ready  | tfe_pkg::req_t, start (func 0) or tick (func 1)
// rsp     | rsp_valid/rsp_ready  | tfe_pkg::rsp_t, one result per request
//
// a tick that interpolates runs ST_EVAL, ST_DIV and ST_DONE from accept to result,
// ST_DIV stepping the bit-per-cycle divider in each lane
// starts that snap, idle ticks and end-of-fade ticks skip ST_DIV
// reset clears the fade state; modulation comes out of reset at full scale
// a new request is taken while the previous result still waits in the result register;
// a stalled result only holds the fsm at its final step

module timed_rgba_fade_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tfe_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tfe_pkg::rsp_t   rsp
);

	tfe_pkg::fade_state_t state_q, state_nxt;
	tfe_pkg::cnt_t        cnt_q;

	// architectural fade state
	tfe_pkg::color_t start_q;
	tfe_pkg::color_t goal_q;
	tfe_pkg::color_t now_q;
	tfe_pkg::time_t  time_now_q;
	tfe_pkg::time_t  time_end_q;
	tfe_pkg::time_t  elapsed_q;
	logic            busy_q;
	logic            overlay_q;
	tfe_pkg::chan_t  mod_q;

	tfe_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;

	tfe_pkg::lane_ctl_t lane_ctl;
	tfe_pkg::color_t    lane_val;
	tfe_pkg::color_t    target;
	tfe_pkg::fade_upd_t cur;
	tfe_pkg::fade_upd_t upd;

	logic                     accept;
	logic                     commit;
	logic                     reached;
	logic                     start_ovl;
	logic [tfe_pkg::TIME_BITS:0] time_sum;
	tfe_pkg::time_t           time_sat;

	assign accept  = req_valid && req_ready;
	assign reached = (time_now_q >= time_end_q);
	assign target  = {req.target_alpha, req.target_blue, req.target_green, req.target_red};

	// overlay stays off only when both the current and the target rgb are black
	assign start_ovl = !((now_q[0] == '0) && (now_q[1] == '0) && (now_q[2] == '0)
		&& (req.target_red == '0) && (req.target_green == '0)
		&& (req.target_blue == '0));

	// elapsed time saturates at the top of the time range
	assign time_sum = {1'b0, time_now_q} + {1'b0, elapsed_q};
	assign time_sat = time_sum[tfe_pkg::TIME_BITS] ? tfe_pkg::TMAX
		: time_sum[tfe_pkg::TIME_BITS-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tfe_pkg::ST_IDLE: begin
				if (accept) state_nxt = tfe_pkg::ST_EVAL;
			end
			tfe_pkg::ST_EVAL: begin
				// only an unfinished fade needs the divider
				if (busy_q && !reached) state_nxt = tfe_pkg::ST_DIV;
				else                    state_nxt = tfe_pkg::ST_DONE;
			end
			tfe_pkg::ST_DIV: begin
				if (cnt_q == tfe_pkg::CNT_LAST) state_nxt = tfe_pkg::ST_DONE;
			end
			tfe_pkg::ST_DONE: begin
				if (commit) state_nxt = tfe_pkg::ST_IDLE;
			end
			default: state_nxt = tfe_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		req_ready     = 1'b0;
		lane_ctl.load = 1'b0;
		lane_ctl.step = 1'b0;
		commit        = 1'b0;
		case (state_q)
			tfe_pkg::ST_IDLE: req_ready     = 1'b1;
			tfe_pkg::ST_EVAL: lane_ctl.load = 1'b1;
			tfe_pkg::ST_DIV:  lane_ctl.step = 1'b1;
			tfe_pkg::ST_DONE: commit        = !rsp_valid_q || rsp_ready;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfe_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (lane_ctl.load)      cnt_q <= '0;
			else if (lane_ctl.step) cnt_q <= cnt_q + 1'b1;
		end
	end

	// one lane per color channel, all sharing the same time ratio
	for (genvar g = 0; g < tfe_pkg::NUM_LANES; g++) begin : g_lane
		tfe_lane u_lane (
			.clk   (clk),
			.ctl   (lane_ctl),
			.from  (start_q[g]),
			.to    (goal_q[g]),
			.t     (time_now_q),
			.e     (time_end_q),
			.value (lane_val[g])
		);
	end

	assign cur.now         = now_q;
	assign cur.in_progress = busy_q;
	assign cur.overlay     = overlay_q;
	assign cur.mod         = mod_q;

	tfe_merge u_merge (
		.start_color (start_q),
		.goal_color  (goal_q),
		.lane_val    (lane_val),
		.cur         (cur),
		.reached     (reached),
		.upd         (upd)
	);

	// fade state: a start loads on accept, every request commits its tick at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			goal_q     <= '0;
			now_q      <= '0;
			time_now_q <= '0;
			time_end_q <= '0;
			elapsed_q  <= '0;
			busy_q     <= 1'b0;
			overlay_q  <= 1'b0;
			mod_q      <= tfe_pkg::CMAX;
		end else if (accept) begin
			if (req.func == tfe_pkg::FUNC_START) begin
				start_q    <= now_q;
				goal_q     <= target;
				time_now_q <= '0;
				time_end_q <= req.duration_ms;
				busy_q     <= 1'b1;
				overlay_q  <= start_ovl;
				if (start_ovl) mod_q <= tfe_pkg::CMAX;
				// the start's own tick counts no time
				elapsed_q  <= '0;
			end else begin
				elapsed_q  <= req.elapsed_ms;
			end
		end else if (commit) begin
			now_q     <= upd.now;
			busy_q    <= upd.in_progress;
			overlay_q <= upd.overlay;
			mod_q     <= upd.mod;
			// an idle tick does not count time
			if (busy_q) time_now_q <= time_sat;
		end
	end

	// result register parts the two sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.cur_red    <= upd.now[0];
			rsp_q.cur_green  <= upd.now[1];
			rsp_q.cur_blue   <= upd.now[2];
			rsp_q.cur_alpha  <= upd.now[tfe_pkg::ALPHA_LANE];
			rsp_q.modulation <= upd.mod;
			rsp_q.overlay_on <= upd.overlay;
			rsp_q.busy_res   <= upd.in_progress;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// without overlay the settled modulation always tracks the current alpha
	a_mod_tracks_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfe_pkg::ST_IDLE && !overlay_q)
			|-> (mod_q == tfe_pkg::CMAX - now_q[tfe_pkg::ALPHA_LANE]))
		else $error("modulation out of step with alpha while overlay is off");

	// the divider runs exactly one pass before the result is committed
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfe_pkg::ST_DIV && cnt_q == tfe_pkg::CNT_LAST)
			|=> (state_q == tfe_pkg::ST_DONE))
		else $error("divider pass did not end in the commit step");

	// an idle tick leaves the color untouched
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !busy_q) |=> ($stable(now_q) && $stable(mod_q) && $stable(overlay_q)))
		else $error("idle tick changed the fade state");

	// a result is never committed over one that was not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten");

endmodule
